// ===== rtl/cfp_pkg.sv =====
package cfp_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned FIELD_W = 32;
   localparam int unsigned INSTR_W = OP_W + 3 * FIELD_W;
   localparam int unsigned TDATA_W = ((INSTR_W + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_LOAD_IMM = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB      = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL      = 3'd3;

   // packed so that op_code sits in the lowest bits
   typedef struct packed {
      logic [FIELD_W-1:0] third_field;
      logic [FIELD_W-1:0] second_field;
      logic [FIELD_W-1:0] first_field;
      logic [OP_W-1:0]    op_code;
   } instr_type;

endpackage

// ===== rtl/constant_fold_peephole_core.sv =====
// Peephole constant folder for a stream of three-address instructions.
//
// Request channel (req_*): one instruction per request; tdata packs op_code,
// first_field, second_field, third_field from the lowest bit up, tlast marks
// the final instruction of a list and flushes every held load.
// Response channel (rsp_*): emitted instructions in the same packing, tlast
// set on the final instruction emitted for a list.
// Up to two load-immediates are held back. An add, subtract or multiply whose
// sources are the two held destinations, in order, collapses with them into
// one held load of the 32-bit wrapped result.
//
// Requests wait in the input register, responses in the response register.
// Throughput: one request per cycle if the receiver keeps up and each yields
// at most one response; a request that yields several responses (flush of
// held loads plus itself, up to three) holds the input register until all
// are loaded, as the single response register takes one instruction per cycle.
// Reset clears the held-load window and both valid flags. A stalled receiver
// holds the response register; a request that must emit then waits in the
// input register and req_tready drops until the response slot frees up, while
// loads taken into the window and folds still advance at one per cycle.
module constant_fold_peephole_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // op_code[2:0], first_field[34:3], second_field[66:35], third_field[98:67]
   input  logic [cfp_pkg::TDATA_W-1:0] req_tdata,
   input  logic                        req_tlast,   // end_of_list
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_op_code[2:0], out_first[34:3], out_second[66:35], out_third[98:67]
   output logic [cfp_pkg::TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tlast    // out_last
);

   // input register
   logic                    in_valid_ff, in_valid_in;
   cfp_pkg::instr_type      in_instr_ff;
   logic                    in_last_ff;

   // held-load window; entry 0 is the older load
   logic [1:0]                   held_count_ff, held_count_in;
   logic [cfp_pkg::FIELD_W-1:0]  held_constant_ff [2];
   logic [cfp_pkg::FIELD_W-1:0]  held_register_ff [2];

   // response register and per-request emit counter
   logic                    rsp_valid_ff, rsp_valid_in;
   cfp_pkg::instr_type      rsp_instr_ff;
   logic                    rsp_last_ff;
   logic [1:0]              emit_idx_ff, emit_idx_in;

   logic                    req_accept;
   logic                    is_arith;
   logic                    take_load;
   logic                    do_fold;
   logic [1:0]              num_rsp;
   logic                    last_rsp;
   logic                    rsp_load;
   logic                    emit_now;
   logic                    commit;
   logic [cfp_pkg::FIELD_W-1:0] fold_value;
   cfp_pkg::instr_type      rsp_instr_sel;
   logic                    rsp_last_sel;
   cfp_pkg::instr_type      cur_as_out;

   assign req_accept = req_tvalid && req_tready;

   // classify the registered request against the window
   always_comb begin
      is_arith  = in_instr_ff.op_code inside {cfp_pkg::OP_ADD, cfp_pkg::OP_SUB,
                                              cfp_pkg::OP_MUL};
      take_load = (in_instr_ff.op_code == cfp_pkg::OP_LOAD_IMM) && !in_last_ff;
      do_fold   = !in_last_ff && is_arith && (held_count_ff == 2'd2) &&
                  (held_register_ff[0] == in_instr_ff.first_field) &&
                  (held_register_ff[1] == in_instr_ff.second_field);
      if (take_load) begin
         num_rsp = (held_count_ff == 2'd2) ? 2'd1 : 2'd0;
      end else if (do_fold) begin
         num_rsp = 2'd0;
      end else begin
         num_rsp = held_count_ff + 2'd1;
      end
   end

   always_comb begin
      case (in_instr_ff.op_code)
         cfp_pkg::OP_ADD: fold_value = held_constant_ff[0] + held_constant_ff[1];
         cfp_pkg::OP_SUB: fold_value = held_constant_ff[0] - held_constant_ff[1];
         default:         fold_value = held_constant_ff[0] * held_constant_ff[1];
      endcase
   end

   // pick the response for the current emit slot: held loads first, then
   // the instruction itself (loads carry zero in the third field)
   always_comb begin
      cur_as_out = in_instr_ff;
      if (in_instr_ff.op_code == cfp_pkg::OP_LOAD_IMM) begin
         cur_as_out.third_field = '0;
      end

      rsp_last_sel = 1'b0;
      if (take_load || (emit_idx_ff < held_count_ff)) begin
         rsp_instr_sel.op_code      = cfp_pkg::OP_LOAD_IMM;
         rsp_instr_sel.first_field  = take_load ? held_constant_ff[0]
                                                : held_constant_ff[emit_idx_ff[0]];
         rsp_instr_sel.second_field = take_load ? held_register_ff[0]
                                                : held_register_ff[emit_idx_ff[0]];
         rsp_instr_sel.third_field  = '0;
      end else begin
         rsp_instr_sel = cur_as_out;
         rsp_last_sel  = in_last_ff;
      end
   end

   assign last_rsp   = (emit_idx_ff == (num_rsp - 2'd1));
   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign emit_now   = in_valid_ff && (num_rsp != 2'd0) && rsp_load;
   assign commit     = in_valid_ff && ((num_rsp == 2'd0) || (rsp_load && last_rsp));
   assign req_tready = !in_valid_ff || commit;

   // next-state for the control registers
   always_comb begin
      in_valid_in  = req_accept ? 1'b1 : (commit ? 1'b0 : in_valid_ff);
      rsp_valid_in = emit_now ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

      emit_idx_in = emit_idx_ff;
      if (commit) begin
         emit_idx_in = 2'd0;
      end else if (emit_now) begin
         emit_idx_in = emit_idx_ff + 2'd1;
      end

      held_count_in = held_count_ff;
      if (commit) begin
         if (take_load) begin
            held_count_in = (held_count_ff == 2'd2) ? 2'd2 : held_count_ff + 2'd1;
         end else if (do_fold) begin
            held_count_in = 2'd1;
         end else begin
            held_count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         emit_idx_ff   <= 2'd0;
         held_count_ff <= 2'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         emit_idx_ff   <= emit_idx_in;
         held_count_ff <= held_count_in;
      end
   end

   // payload registers: capture request, load response, update the window
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_instr_ff <= cfp_pkg::instr_type'(req_tdata[cfp_pkg::INSTR_W-1:0]);
         in_last_ff  <= req_tlast;
      end
      if (emit_now) begin
         rsp_instr_ff <= rsp_instr_sel;
         rsp_last_ff  <= rsp_last_sel;
      end
      if (commit && take_load) begin
         if (held_count_ff == 2'd2) begin
            // slide: oldest went out, newest lands in slot 1
            held_constant_ff[0] <= held_constant_ff[1];
            held_register_ff[0] <= held_register_ff[1];
            held_constant_ff[1] <= in_instr_ff.first_field;
            held_register_ff[1] <= in_instr_ff.second_field;
         end else begin
            held_constant_ff[held_count_ff[0]] <= in_instr_ff.first_field;
            held_register_ff[held_count_ff[0]] <= in_instr_ff.second_field;
         end
      end else if (commit && do_fold) begin
         held_constant_ff[0] <= fold_value;
         held_register_ff[0] <= in_instr_ff.third_field;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cfp_pkg::TDATA_W - cfp_pkg::INSTR_W){1'b0}}, rsp_instr_ff};
   assign rsp_tlast  = rsp_last_ff;

   // window never overfills, and the emit counter stays inside the flush
   a_held_count_range: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd3)
      else $error("held window count out of range");

   a_emit_idx_bound: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (emit_idx_ff <= held_count_ff))
      else $error("emit index beyond held loads");

   a_fold_leaves_one: assert property (@(posedge clock) disable iff (reset)
      (commit && do_fold) |=> (held_count_ff == 2'd1))
      else $error("fold did not leave exactly one held load");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (commit && !take_load && !do_fold) |=> (held_count_ff == 2'd0))
      else $error("flush did not empty the window");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   // opcodes the folder never touches; they only flush the window
   localparam logic [cfp_pkg::OP_W-1:0] OP_OTHER_4 = 3'd4;
   localparam logic [cfp_pkg::OP_W-1:0] OP_OTHER_5 = 3'd5;
   localparam logic [cfp_pkg::OP_W-1:0] OP_OTHER_6 = 3'd6;
   localparam logic [cfp_pkg::OP_W-1:0] OP_OTHER_7 = 3'd7;

   localparam int HOLDOFF_CYCLES = 80;
   localparam int DRAIN_LIMIT    = 5000;

   typedef struct {
      logic [cfp_pkg::OP_W-1:0]    op_code;
      logic [cfp_pkg::FIELD_W-1:0] first_field;
      logic [cfp_pkg::FIELD_W-1:0] second_field;
      logic [cfp_pkg::FIELD_W-1:0] third_field;
      logic                        last;
   } emitted_instr_type;

   // Shadow of the held-load window plus the queue of instructions the block
   // still owes on its response channel.
   class scoreboard_type;
      logic [1:0]                  held_count;
      logic [cfp_pkg::FIELD_W-1:0] held_constant [2];
      logic [cfp_pkg::FIELD_W-1:0] held_register [2];
      emitted_instr_type           expected_emits [$];
      int                          mismatches;
      int                          responses;

      function new();
         held_count    = '0;
         held_constant = '{default: '0};
         held_register = '{default: '0};
         mismatches    = 0;
         responses     = 0;
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatches++;
      endtask

      function int pending();
         return expected_emits.size();
      endfunction

      function void queue_emit(logic [cfp_pkg::OP_W-1:0] op,
                               logic [cfp_pkg::FIELD_W-1:0] a,
                               logic [cfp_pkg::FIELD_W-1:0] b,
                               logic [cfp_pkg::FIELD_W-1:0] c,
                               logic last);
         emitted_instr_type e;
         e.op_code      = op;
         e.first_field  = a;
         e.second_field = b;
         e.third_field  = c;
         e.last         = last;
         expected_emits.push_back(e);
      endfunction

      // Advance the window by one accepted request and queue what it emits.
      function void note_request(cfp_pkg::instr_type ins, logic last);
         logic [cfp_pkg::FIELD_W-1:0] folded;
         logic                        is_arith;
         is_arith = (ins.op_code == cfp_pkg::OP_ADD) ||
                    (ins.op_code == cfp_pkg::OP_SUB) ||
                    (ins.op_code == cfp_pkg::OP_MUL);

         if (ins.op_code == cfp_pkg::OP_LOAD_IMM && !last) begin
            // a third load pushes the oldest one out and slides the window
            if (held_count == 2) begin
               queue_emit(cfp_pkg::OP_LOAD_IMM, held_constant[0], held_register[0],
                          '0, 1'b0);
               held_constant[0] = held_constant[1];
               held_register[0] = held_register[1];
               held_count = 2'd1;
            end
            held_constant[held_count] = ins.first_field;
            held_register[held_count] = ins.second_field;
            held_count++;
            return;
         end

         if (!last && is_arith && held_count == 2 &&
             held_register[0] == ins.first_field &&
             held_register[1] == ins.second_field) begin
            case (ins.op_code)
               cfp_pkg::OP_ADD: folded = held_constant[0] + held_constant[1];
               cfp_pkg::OP_SUB: folded = held_constant[0] - held_constant[1];
               default:         folded = held_constant[0] * held_constant[1];
            endcase
            held_constant[0] = folded;
            held_register[0] = ins.third_field;
            held_constant[1] = '0;
            held_register[1] = '0;
            held_count = 2'd1;
            return;
         end

         // no fold: flush the window in order, then pass the request itself
         for (int i = 0; i < held_count; i++)
            queue_emit(cfp_pkg::OP_LOAD_IMM, held_constant[i], held_register[i],
                       '0, 1'b0);
         held_count    = '0;
         held_constant = '{default: '0};
         held_register = '{default: '0};
         if (ins.op_code == cfp_pkg::OP_LOAD_IMM)
            queue_emit(cfp_pkg::OP_LOAD_IMM, ins.first_field, ins.second_field,
                       '0, last);
         else
            queue_emit(ins.op_code, ins.first_field, ins.second_field,
                       ins.third_field, last);
      endfunction

      task check_response(logic [cfp_pkg::TDATA_W-1:0] word, logic last);
         cfp_pkg::instr_type got;
         emitted_instr_type  want;
         got = word[cfp_pkg::INSTR_W-1:0];
         responses++;
         if (expected_emits.size() == 0) begin
            report_mismatch($sformatf("response %0d with nothing pending, op %0d",
                                      responses, got.op_code));
            return;
         end
         want = expected_emits.pop_front();
         if (got.op_code !== want.op_code)
            report_mismatch($sformatf("response %0d op_code %0d, want %0d",
                                      responses, got.op_code, want.op_code));
         if (got.first_field !== want.first_field)
            report_mismatch($sformatf("response %0d first %h, want %h",
                                      responses, got.first_field, want.first_field));
         if (got.second_field !== want.second_field)
            report_mismatch($sformatf("response %0d second %h, want %h",
                                      responses, got.second_field, want.second_field));
         if (got.third_field !== want.third_field)
            report_mismatch($sformatf("response %0d third %h, want %h",
                                      responses, got.third_field, want.third_field));
         if (last !== want.last)
            report_mismatch($sformatf("response %0d tlast %b, want %b",
                                      responses, last, want.last));
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [cfp_pkg::TDATA_W-1:0] req_tdata = '0;   // op_code, first, second, third, zero pad
   logic                        req_tlast = 1'b0; // end_of_list
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [cfp_pkg::TDATA_W-1:0] rsp_tdata;        // out_op_code, out_first, out_second, out_third
   logic                        rsp_tlast;        // out_last

   scoreboard_type board = new();

   int  sink_holdoff = 0;   // long receiver stall, counted down by the sink process
   bit  calm = 1'b0;        // no idling on either side once set
   int  issued = 0;

   constant_fold_peephole_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block wedges.
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: random short stalls, one long hold-off on request, none when calm.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (sink_holdoff > 0) begin
            rsp_tready <= 1'b0;
            sink_holdoff--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 3) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Sample responses at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_response(rsp_tdata, rsp_tlast);
   end

   // Drive one request from a falling edge and hold it until the block takes it.
   // Returns at the falling edge after acceptance with tvalid still high.
   task automatic issue(logic [cfp_pkg::OP_W-1:0] op, logic [cfp_pkg::FIELD_W-1:0] a,
                        logic [cfp_pkg::FIELD_W-1:0] b, logic [cfp_pkg::FIELD_W-1:0] c,
                        logic last);
      cfp_pkg::instr_type          ins;
      logic [cfp_pkg::TDATA_W-1:0] word;
      ins.op_code      = op;
      ins.first_field  = a;
      ins.second_field = b;
      ins.third_field  = c;
      word = '0;
      word[cfp_pkg::INSTR_W-1:0] = ins;
      // insert a short idle burst now and then
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tdata  <= word;
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(ins, last);
      issued++;
      @(negedge clock);
   endtask

   // Drop tvalid and wait until every owed response has been taken or DRAIN_LIMIT runs out.
   task automatic drain_responses();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (board.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      @(negedge clock);
   endtask

   // Change receiver behavior away from the falling edge the sink acts on.
   task automatic set_sink(int holdoff, bit quiet);
      @(posedge clock);
      sink_holdoff = holdoff;
      calm = quiet;
      @(negedge clock);
   endtask

   function automatic logic [cfp_pkg::FIELD_W-1:0] pick_reg();
      if ($urandom_range(0, 9) < 8)
         return cfp_pkg::FIELD_W'($urandom_range(0, 7));
      return $urandom;
   endfunction

   function automatic logic [cfp_pkg::FIELD_W-1:0] pick_const();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         4:       return cfp_pkg::FIELD_W'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   // Mostly fold chains with random content; the rest broken chains and noise.
   task automatic random_items(int target);
      logic [cfp_pkg::FIELD_W-1:0] r_old, r_new, r_dst;
      logic [cfp_pkg::OP_W-1:0]    op;
      int                          kind;
      while (issued < target) begin
         kind = $urandom_range(0, 9);
         if (kind <= 7) begin
            r_old = pick_reg();
            r_new = pick_reg();
            issue(cfp_pkg::OP_LOAD_IMM, pick_const(), r_old, $urandom, 1'b0);
            issue(cfp_pkg::OP_LOAD_IMM, pick_const(), r_new, $urandom, 1'b0);
            repeat ($urandom_range(1, 3)) begin
               op    = cfp_pkg::OP_W'($urandom_range(cfp_pkg::OP_ADD, cfp_pkg::OP_MUL));
               r_dst = pick_reg();
               if (kind >= 6) begin
                  // broken chain: swapped or stray source registers
                  issue(op, ($urandom_range(0, 1) ? r_new : pick_reg()), r_old, r_dst,
                        ($urandom_range(0, 11) == 0));
               end else begin
                  issue(op, r_old, r_new, r_dst, ($urandom_range(0, 11) == 0));
               end
               r_old = r_dst;
               r_new = pick_reg();
               issue(cfp_pkg::OP_LOAD_IMM, pick_const(), r_new, '0,
                     ($urandom_range(0, 15) == 0));
            end
         end else begin
            op = cfp_pkg::OP_W'($urandom_range(0, 7));
            issue(op, ($urandom_range(0, 1) ? pick_const() : pick_reg()), pick_reg(),
                  pick_reg(), ($urandom_range(0, 7) == 0));
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fold, then fold the folded load again
      issue(cfp_pkg::OP_LOAD_IMM, 32'd5, 32'd1, 32'd0, 1'b0);
      issue(cfp_pkg::OP_LOAD_IMM, 32'd7, 32'd2, 32'hDEAD_BEEF, 1'b0);  // third field ignored
      issue(cfp_pkg::OP_ADD, 32'd1, 32'd2, 32'd3, 1'b0);
      issue(cfp_pkg::OP_LOAD_IMM, 32'hFFFF_FFFF, 32'd4, 32'd0, 1'b0);
      issue(cfp_pkg::OP_MUL, 32'd3, 32'd4, 32'd5, 1'b0);
      // third load slides the window, then add overflows past the signed maximum
      issue(cfp_pkg::OP_LOAD_IMM, 32'h7FFF_FFFF, 32'd6, 32'd0, 1'b0);
      issue(cfp_pkg::OP_LOAD_IMM, 32'd1, 32'd7, 32'd0, 1'b0);
      issue(cfp_pkg::OP_ADD, 32'd6, 32'd7, 32'd8, 1'b0);
      issue(cfp_pkg::OP_LOAD_IMM, 32'd1, 32'd9, 32'd0, 1'b0);
      issue(cfp_pkg::OP_SUB, 32'd8, 32'd9, 32'd10, 1'b0);
      // sources in the wrong order: no fold
      issue(cfp_pkg::OP_LOAD_IMM, 32'd2, 32'd11, 32'd0, 1'b0);
      issue(cfp_pkg::OP_SUB, 32'd11, 32'd10, 32'd12, 1'b0);
      // only one load held: no fold
      issue(cfp_pkg::OP_LOAD_IMM, 32'd3, 32'd1, 32'd0, 1'b0);
      issue(cfp_pkg::OP_MUL, 32'd1, 32'd1, 32'd2, 1'b0);
      // matching fold on the final instruction must not fold
      issue(cfp_pkg::OP_LOAD_IMM, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b0);
      issue(cfp_pkg::OP_LOAD_IMM, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0);
      issue(cfp_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // passthrough opcodes, with and without held loads
      issue(OP_OTHER_4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      issue(cfp_pkg::OP_LOAD_IMM, 32'd0, 32'd0, 32'd0, 1'b0);
      issue(OP_OTHER_5, 32'd0, 32'd0, 32'd0, 1'b0);
      issue(OP_OTHER_6, 32'd1, 32'd2, 32'd3, 1'b0);
      // load marked final flushes and carries tlast itself
      issue(cfp_pkg::OP_LOAD_IMM, 32'd9, 32'd3, 32'hFFFF_FFFF, 1'b1);
      issue(OP_OTHER_7, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 1'b1);

      random_items(110);

      // stall the receiver for a long stretch while requests keep coming
      drain_responses();
      set_sink(HOLDOFF_CYCLES, 1'b0);
      random_items(150);

      // pause the sender until everything owed has come out
      drain_responses();
      random_items(230);

      // last stretch without idling
      drain_responses();
      set_sink(0, 1'b1);
      random_items(265);

      drain_responses();
      repeat (8) @(posedge clock);
      if (board.pending() != 0)
         board.report_mismatch($sformatf("%0d responses never arrived", board.pending()));

      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
